// ===== design/cc12_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc12_pkg
// Types, constants and round functions for the ChaCha12 keystream generator.
// ----------------------------------------------------------------------------
package cc12_pkg;

    localparam int          DOUBLE_ROUNDS_DEF = 6;
    localparam logic [63:0] PCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC = 64'd11634580027462260723;
    localparam int          PAIR_W  = 63;

    typedef logic [31:0]       word_t;
    typedef word_t [15:0]      blk_t;
    typedef word_t [7:0]       key_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646E;
    localparam word_t SIGMA2 = 32'h79622D32;
    localparam word_t SIGMA3 = 32'h6B206574;

    function automatic quad_t qr(input word_t a, input word_t b,
                                 input word_t c, input word_t d);
        word_t ta, tb, tc, td;
        quad_t q;
        ta = a; tb = b; tc = c; td = d;
        ta = ta + tb; td = td ^ ta; td = {td[15:0], td[31:16]};
        tc = tc + td; tb = tb ^ tc; tb = {tb[19:0], tb[31:20]};
        ta = ta + tb; td = td ^ ta; td = {td[23:0], td[31:24]};
        tc = tc + td; tb = tb ^ tc; tb = {tb[24:0], tb[31:25]};
        q.a = ta; q.b = tb; q.c = tc; q.d = td;
        return q;
    endfunction

    // column round when diag is low, diagonal round when high
    function automatic blk_t half_round(input blk_t x, input logic diag);
        blk_t  y;
        quad_t q0, q1, q2, q3;
        y = x;
        if (!diag) begin
            q0 = qr(x[0], x[4], x[8],  x[12]);
            q1 = qr(x[1], x[5], x[9],  x[13]);
            q2 = qr(x[2], x[6], x[10], x[14]);
            q3 = qr(x[3], x[7], x[11], x[15]);
            y[0] = q0.a; y[4] = q0.b; y[8]  = q0.c; y[12] = q0.d;
            y[1] = q1.a; y[5] = q1.b; y[9]  = q1.c; y[13] = q1.d;
            y[2] = q2.a; y[6] = q2.b; y[10] = q2.c; y[14] = q2.d;
            y[3] = q3.a; y[7] = q3.b; y[11] = q3.c; y[15] = q3.d;
        end else begin
            q0 = qr(x[0], x[5], x[10], x[15]);
            q1 = qr(x[1], x[6], x[11], x[12]);
            q2 = qr(x[2], x[7], x[8],  x[13]);
            q3 = qr(x[3], x[4], x[9],  x[14]);
            y[0] = q0.a; y[5] = q0.b; y[10] = q0.c; y[15] = q0.d;
            y[1] = q1.a; y[6] = q1.b; y[11] = q1.c; y[12] = q1.d;
            y[2] = q2.a; y[7] = q2.b; y[8]  = q2.c; y[13] = q2.d;
            y[3] = q3.a; y[4] = q3.b; y[9]  = q3.c; y[14] = q3.d;
        end
        return y;
    endfunction

    function automatic blk_t init_state(input key_t key, input logic [PAIR_W-1:0] pair);
        blk_t s;
        s[0] = SIGMA0; s[1] = SIGMA1; s[2] = SIGMA2; s[3] = SIGMA3;
        for (int i = 0; i < 8; i++) begin
            s[4+i] = key[i];
        end
        s[12] = pair[34:3];
        s[13] = {4'b0, pair[62:35]};
        s[14] = '0;
        s[15] = '0;
        return s;
    endfunction

    function automatic word_t pcg_out(input logic [63:0] st);
        logic [63:0] t;
        word_t       xs;
        logic [63:0] dbl;
        t   = ((st >> 18) ^ st) >> 27;
        xs  = t[31:0];
        dbl = {xs, xs} >> st[63:59];
        return dbl[31:0];
    endfunction

endpackage

// ===== design/chacha12_keystream_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha12_keystream_generator
// Pipelined ChaCha keystream pair generator with a PCG32-expanded key.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports                              Payload
// s_       in         s_valid, s_ready                   s_pair_index[62:0]
// m_       out        m_valid, m_ready                   m_word_*, m_uniform_*
// cfg_     in         cfg_valid, cfg_ready               cfg_seed[63:0]
//
// One transaction per cycle while the output is not stalled; the result passes
// the input register, one stage per column or diagonal round and the output
// register.
// Key expansion runs 8 PCG steps, each through EXP_LL, EXP_LH, EXP_HL, EXP_SUM
// and EXP_OUT on one shared 32x32 multiplier, after reset and after every seed
// write; s_ready and cfg_ready are low meanwhile. cfg_ready also waits for an
// empty pipeline, and s_ready is low while cfg_valid is high.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module chacha12_keystream_generator
    import cc12_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [63:0]       cfg_seed,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [PAIR_W-1:0] s_pair_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_word_even,
    output logic [31:0]       m_word_odd,
    output logic [23:0]       m_uniform_even,
    output logic [23:0]       m_uniform_odd
);

    localparam int NS = 2 * DOUBLE_ROUNDS;

    // ---------------- key expansion ----------------
    typedef enum logic [2:0] {
        EXP_LL, EXP_LH, EXP_HL, EXP_SUM, EXP_OUT
    } exp_t;

    exp_t        phase_reg;
    logic        busy_reg;
    logic [2:0]  cnt_reg;
    logic [63:0] st_reg;
    logic [63:0] p0_reg;
    logic [31:0] cross_reg;
    key_t        key_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    always_comb begin
        unique case (phase_reg)
            EXP_LL:  begin mul_a = st_reg[31:0];  mul_b = PCG_MUL[31:0];  end
            EXP_LH:  begin mul_a = st_reg[31:0];  mul_b = PCG_MUL[63:32]; end
            EXP_HL:  begin mul_a = st_reg[63:32]; mul_b = PCG_MUL[31:0];  end
            default: begin mul_a = st_reg[31:0];  mul_b = PCG_MUL[31:0];  end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            phase_reg <= EXP_LL;
            cnt_reg   <= '0;
            st_reg    <= '0;
        end else if (!busy_reg) begin
            if (cfg_valid && cfg_ready) begin
                busy_reg  <= 1'b1;
                phase_reg <= EXP_LL;
                cnt_reg   <= '0;
                st_reg    <= cfg_seed;
            end
        end else begin
            unique case (phase_reg)
                EXP_LL: begin
                    p0_reg    <= prod;
                    phase_reg <= EXP_LH;
                end
                EXP_LH: begin
                    cross_reg <= prod[31:0];
                    phase_reg <= EXP_HL;
                end
                EXP_HL: begin
                    cross_reg <= cross_reg + prod[31:0];
                    phase_reg <= EXP_SUM;
                end
                EXP_SUM: begin
                    st_reg    <= p0_reg + {cross_reg, 32'b0} + PCG_INC;
                    phase_reg <= EXP_OUT;
                end
                EXP_OUT: begin
                    key_reg[cnt_reg] <= pcg_out(st_reg);
                    phase_reg        <= EXP_LL;
                    cnt_reg          <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        busy_reg <= 1'b0;
                    end
                end
                default: phase_reg <= EXP_LL;
            endcase
        end
    end

    // ---------------- round pipeline ----------------
    logic                 adv;
    logic                 pipe_empty;
    logic [NS:0]          vld_reg;
    logic [PAIR_W-1:0]    pair_reg [0:NS];
    blk_t                 x_reg    [1:NS];
    logic                 m_valid_reg;
    word_t                even_reg, odd_reg;

    assign adv        = !m_valid_reg || m_ready;
    assign s_ready    = adv && !busy_reg && !cfg_valid;
    assign pipe_empty = (vld_reg == '0) && !m_valid_reg;
    assign cfg_ready  = !busy_reg && pipe_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pair_reg[0] <= s_pair_index;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_round
        blk_t x_in;
        if (k == 0) begin : g_first
            assign x_in = init_state(key_reg, pair_reg[0]);
        end else begin : g_rest
            assign x_in = x_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                pair_reg[k+1] <= pair_reg[k];
                x_reg[k+1]    <= half_round(x_in, 1'(k % 2));
            end
        end
    end

    blk_t       s_fin;
    logic [3:0] off_even, off_odd;
    word_t      sum_even, sum_odd;

    always_comb begin
        s_fin    = init_state(key_reg, pair_reg[NS]);
        off_even = {pair_reg[NS][2:0], 1'b0};
        off_odd  = {pair_reg[NS][2:0], 1'b1};
        sum_even = x_reg[NS][off_even] + s_fin[off_even];
        sum_odd  = x_reg[NS][off_odd]  + s_fin[off_odd];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            even_reg <= sum_even;
            odd_reg  <= sum_odd;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_word_even    = even_reg;
    assign m_word_odd     = odd_reg;
    assign m_uniform_even = even_reg[31:8];
    assign m_uniform_odd  = odd_reg[31:8];

    // ---------------- assertions ----------------
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready && !cfg_ready)
        else $error("transaction accepted during key expansion");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transaction not in pipeline");

    a_exp_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && phase_reg == EXP_OUT && cnt_reg == 3'd7 |=> !busy_reg)
        else $error("key expansion did not finish");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

endmodule

// ===== tb/chacha12_keystream_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha12_keystream_generator_tb
// Self-checking bench: a behavioral ChaCha/PCG32 keystream predictor checks
// every result transaction against a queue of expected keystream pairs, over
// several seeds, bursty input and a stalling output.
// ----------------------------------------------------------------------------
module chacha12_keystream_generator_tb;
    import cc12_pkg::*;

    typedef struct {
        logic [31:0] w_even;
        logic [31:0] w_odd;
        logic [23:0] u_even;
        logic [23:0] u_odd;
    } pair_res_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [63:0]       cfg_seed = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [PAIR_W-1:0] s_pair_index = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [31:0]       m_word_even, m_word_odd;
    logic [23:0]       m_uniform_even, m_uniform_odd;

    chacha12_keystream_generator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_seed(cfg_seed),
        .s_valid(s_valid), .s_ready(s_ready), .s_pair_index(s_pair_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_word_even(m_word_even), .m_word_odd(m_word_odd),
        .m_uniform_even(m_uniform_even), .m_uniform_odd(m_uniform_odd)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [31:0]       key_words [8];
    logic [PAIR_W-1:0] pair_pending [$];
    pair_res_t         keystream_expected [$];
    int                fail_count = 0;
    bit                hold_rx = 1'b0;
    bit                in_acc = 1'b0;
    bit                cfg_acc = 1'b0;
    int                long_hold = 0;
    int                gap_left = 0;
    int                burst_left = 0;
    int                rx_phase = 0;

    function automatic logic [31:0] rotl32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic expand_seed(input logic [63:0] sd);
        logic [63:0] st;
        logic [31:0] xs;
        int          rot;
        st = sd;
        for (int i = 0; i < 8; i++) begin
            st = st * 64'd6364136223846793005 + 64'd11634580027462260723;
            xs = 32'(((st >> 18) ^ st) >> 27);
            rot = int'(st[63:59]);
            key_words[i] = (rot == 0) ? xs : ((xs >> rot) | (xs << (32 - rot)));
        end
    endtask

    function automatic void mix(inout logic [31:0] x[16], input int a, int b, int c, int d);
        x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 7);
    endfunction

    function automatic pair_res_t keystream_pair(logic [PAIR_W-1:0] pair);
        logic [31:0] s[16];
        logic [31:0] x[16];
        logic [63:0] ctr;
        int          off;
        pair_res_t   r;
        ctr = 64'(pair >> 3);
        s[0] = 32'h61707865; s[1] = 32'h3320646E;
        s[2] = 32'h79622D32; s[3] = 32'h6B206574;
        for (int i = 0; i < 8; i++) s[4+i] = key_words[i];
        s[12] = ctr[31:0]; s[13] = ctr[63:32]; s[14] = '0; s[15] = '0;
        x = s;
        for (int r2 = 0; r2 < 6; r2++) begin
            mix(x, 0, 4, 8, 12); mix(x, 1, 5, 9, 13);
            mix(x, 2, 6, 10, 14); mix(x, 3, 7, 11, 15);
            mix(x, 0, 5, 10, 15); mix(x, 1, 6, 11, 12);
            mix(x, 2, 7, 8, 13); mix(x, 3, 4, 9, 14);
        end
        off = int'(pair[2:0]) * 2;
        r.w_even = x[off] + s[off];
        r.w_odd = x[off+1] + s[off+1];
        r.u_even = r.w_even[31:8];
        r.u_odd = r.w_odd[31:8];
        return r;
    endfunction

    // handshakes seen at the rising edge
    always @(posedge aclk) begin
        in_acc  <= s_valid && s_ready;
        cfg_acc <= cfg_valid && cfg_ready;
    end

    // input driver: bursts and gaps
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_acc) begin
                void'(pair_pending.pop_front());
            end
            if (!s_valid || in_acc) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pair_pending.size() > 0) begin
                    s_valid <= 1'b1;
                    s_pair_index <= pair_pending[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_ready <= 1'b0;
        end else if (hold_rx) begin
            long_hold <= 200;
            m_ready <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1;
            if ((rx_phase / 64) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 99) < 65);
        end
    end

    // monitor
    always @(posedge aclk) begin
        pair_res_t e;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                keystream_expected.push_back(keystream_pair(s_pair_index));
            end
            if (m_valid && m_ready) begin
                if (keystream_expected.size() == 0) begin
                    $display("%0t unexpected result: actual %h %h", $realtime,
                             m_word_even, m_word_odd);
                    fail_count = fail_count + 1;
                end else begin
                    e = keystream_expected.pop_front();
                    if (m_word_even !== e.w_even || m_word_odd !== e.w_odd ||
                        m_uniform_even !== e.u_even || m_uniform_odd !== e.u_odd) begin
                        $display("%0t mismatch: expected %h %h %h %h actual %h %h %h %h",
                                 $realtime, e.w_even, e.w_odd, e.u_even, e.u_odd,
                                 m_word_even, m_word_odd, m_uniform_even, m_uniform_odd);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic drain();
        while (pair_pending.size() != 0 || s_valid) @(posedge aclk);
        while (keystream_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] sd);
        @(negedge aclk);
        cfg_seed <= sd;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_acc);
        cfg_valid <= 1'b0;
        expand_seed(sd);
    endtask

    function automatic logic [PAIR_W-1:0] rand_pair();
        logic [PAIR_W-1:0] p;
        p = 63'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: p = p & 63'h3F;
            1: p = p & 63'hFFFF_FFFF;
            default: ;
        endcase
        return p;
    endfunction

    logic [63:0] seeds [6];

    initial begin
        seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        seeds[1] = 64'h1;
        seeds[2] = {$urandom, $urandom};
        seeds[3] = {$urandom, $urandom};
        seeds[4] = 64'h8000_0000_0000_0000;
        seeds[5] = {$urandom, $urandom};
        expand_seed(64'h0);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 16; i++) pair_pending.push_back(63'(i));
        pair_pending.push_back('1);
        pair_pending.push_back(63'h7FFF_FFFF_FFFF_FFF8);
        pair_pending.push_back(63'h0000_0007_FFFF_FFF8);
        pair_pending.push_back(63'h0000_0008_0000_0000);
        pair_pending.push_back(63'h5555_5555_5555_5555);
        pair_pending.push_back(63'h2AAA_AAAA_AAAA_AAAA);
        drain();

        // long receiver hold while the sender keeps offering
        hold_rx = 1'b1;
        for (int i = 0; i < 120; i++) pair_pending.push_back(rand_pair());
        @(posedge aclk);
        hold_rx = 1'b0;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_seed(seeds[ph]);
            for (int i = 0; i < 280; i++) pair_pending.push_back(rand_pair());
            drain();
        end
        write_seed(64'h0);
        for (int i = 0; i < 40; i++) pair_pending.push_back(rand_pair());
        drain();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
